FILE: rtl/rau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand and result widths, opcode and status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_BITS = 32;
   localparam int IN_W         = 32;
   localparam int OPCODE_W     = 3;
   localparam int NUM_W        = 64;
   localparam int DEN_W        = 62;
   localparam int STATUS_W     = 2;
   localparam int PROD_W       = 2 * OPERAND_BITS;
   localparam int MAG_W        = NUM_W - 1;
   localparam int GK_W         = $clog2(MAG_W);
   localparam int DCNT_W       = $clog2(MAG_W + 1);

   // opcodes; the two unused codes act as reduce
   localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_INV = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_RED = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZDEN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_FIX, S_GINIT, S_GCD, S_GEND,
      S_DIVN0, S_DIVN, S_DIVD0, S_DIVD, S_FIN
   } state_type;

   typedef enum logic [1:0] {MSEL_0, MSEL_1, MSEL_2} mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        comb;
      logic        fix;
      logic        ginit;
      logic        gcd_step;
      logic        gend;
      logic        div_start;
      logic        div_sel_den;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic n_zero;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/rau_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_req_if: request channel
// Valid/ready channel carrying one opcode and two operand fractions per beat.
// ----------------------------------------------------------------------------
interface rau_req_if;
   import rau_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic signed [IN_W-1:0] a_num;
   logic signed [IN_W-1:0] a_den;
   logic signed [IN_W-1:0] b_num;
   logic signed [IN_W-1:0] b_den;

   modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface
`default_nettype wire

FILE: rtl/rau_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_rsp_if: response channel
// Valid/ready channel carrying one reduced fraction and a status per beat.
// ----------------------------------------------------------------------------
interface rau_rsp_if;
   import rau_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [NUM_W-1:0]  res_num;
   logic [DEN_W-1:0]         res_den;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/rational_arithmetic_unit_top.sv
`default_nettype none
// A request beat carries an opcode (add, subtract, multiply, divide, invert or
// reduce) and two fractions; each response beat returns the result in lowest
// terms with the sign on the numerator, plus a status. One item is in work at
// a time: an item that ends in an error goes straight to the output, one whose
// result is zero skips the GCD and the divider, and any other one runs the
// multiply, combine and sign-fix steps, the binary-GCD loop and two passes of
// the one-bit-per-cycle restoring divider. The GCD loop and the shared
// divider take most of an item's time. A new request is taken as soon as the
// previous result sits in the output register, even if it has not yet left.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: rational arithmetic unit
// Joins the sequencer and the datapath to the request and response channels.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top (
   input  wire logic  clock,
   input  wire logic  reset,
   rau_req_if.sink    req_chan,
   rau_rsp_if.source  rsp_chan
);
   import rau_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath
   rau_dp u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .sts     (sts),
      .opcode  (req_chan.opcode),
      .a_num   (req_chan.a_num),
      .a_den   (req_chan.a_den),
      .b_num   (req_chan.b_num),
      .b_den   (req_chan.b_den),
      .res_num (rsp_chan.res_num),
      .res_den (rsp_chan.res_den),
      .status  (rsp_chan.status)
   );

endmodule
`default_nettype wire

FILE: rtl/rau_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through multiply, combine, GCD and divide phases and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rau_pkg::cmd_type       cmd,
   input  wire rau_pkg::sts_type  sts
);
   import rau_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // state and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = MSEL_0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            if (sts.err) begin
               state_in = S_FIN;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MSEL_0;
               state_in    = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_2;
            state_in    = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_GINIT;
         end
         S_GINIT: begin
            cmd.ginit = 1'b1;
            state_in  = sts.n_zero ? S_FIN : S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               state_in = S_GEND;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_GEND: begin
            cmd.gend = 1'b1;
            state_in = S_DIVN0;
         end
         S_DIVN0: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVN;
         end
         S_DIVN: begin
            if (sts.div_done) begin
               state_in = S_DIVD0;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DIVD0: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_den = 1'b1;
            state_in        = S_DIVD;
         end
         S_DIVD: begin
            if (sts.div_done) begin
               state_in = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold a result until its beat is taken
   assign out_valid_in = (out_valid_ff && !rsp_ready) || cmd.out_load;
   assign rsp_valid    = out_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/rau_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand capture, shared multiplier, combine and sign fix, binary GCD,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module rau_dp (
   input  wire logic                             clock,
   input  wire rau_pkg::cmd_type                 cmd,
   output rau_pkg::sts_type                      sts,
   input  wire logic [rau_pkg::OPCODE_W-1:0]     opcode,
   input  wire logic signed [rau_pkg::IN_W-1:0]  a_num,
   input  wire logic signed [rau_pkg::IN_W-1:0]  a_den,
   input  wire logic signed [rau_pkg::IN_W-1:0]  b_num,
   input  wire logic signed [rau_pkg::IN_W-1:0]  b_den,
   output logic signed [rau_pkg::NUM_W-1:0]      res_num,
   output logic [rau_pkg::DEN_W-1:0]             res_den,
   output logic [rau_pkg::STATUS_W-1:0]          status
);
   import rau_pkg::*;

   localparam logic signed [OPERAND_BITS-1:0] OP_MIN = {1'b1, {(OPERAND_BITS-1){1'b0}}};

   function automatic logic signed [OPERAND_BITS-1:0] sat_op(
      input logic signed [IN_W-1:0] raw);
      logic signed [OPERAND_BITS-1:0] v;
      v = raw[OPERAND_BITS-1:0];
      if (v == OP_MIN) begin
         v = v + OPERAND_BITS'(1);
      end
      return v;
   endfunction

   logic [OPCODE_W-1:0]            op_ff;
   logic signed [OPERAND_BITS-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [STATUS_W-1:0]            st_ff, st_in;
   logic signed [OPERAND_BITS-1:0] an_s, ad_s, bn_s, bd_s;
   logic                           uses_b;

   // saturate operands and derive the early status
   always_comb begin
      an_s   = sat_op(a_num);
      ad_s   = sat_op(a_den);
      bn_s   = sat_op(b_num);
      bd_s   = sat_op(b_den);
      uses_b = (opcode <= OP_DIV);
      if (ad_s == '0 || (uses_b && bd_s == '0)) begin
         st_in = ST_ZDEN;
      end else if ((opcode == OP_DIV && bn_s == '0) || (opcode == OP_INV && an_s == '0)) begin
         st_in = ST_DIVZ;
      end else begin
         st_in = ST_OK;
      end
   end

   // capture operands with positive denominators
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode;
         st_ff <= st_in;
         an_ff <= (ad_s < 0) ? -an_s : an_s;
         ad_ff <= (ad_s < 0) ? -ad_s : ad_s;
         bn_ff <= (bd_s < 0) ? -bn_s : bn_s;
         bd_ff <= (bd_s < 0) ? -bd_s : bd_s;
      end
   end

   // shared multiplier, one product per step
   logic signed [OPERAND_BITS-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]       prod;
   logic signed [NUM_W-1:0]        p0_ff, p1_ff, p2_ff;

   always_comb begin
      case (cmd.mul_sel)
         MSEL_0: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         MSEL_1: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_MUL) ? bd_ff : bn_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_0:  p0_ff <= NUM_W'(prod);
            MSEL_1:  p1_ff <= NUM_W'(prod);
            default: p2_ff <= NUM_W'(prod);
         endcase
      end
   end

   // combine products, then move the sign to the numerator
   logic signed [NUM_W-1:0] n_ff, d_ff, n_c, d_c;

   always_comb begin
      case (op_ff) inside
         OP_ADD: begin
            n_c = p0_ff + p1_ff;
            d_c = p2_ff;
         end
         OP_SUB: begin
            n_c = p0_ff - p1_ff;
            d_c = p2_ff;
         end
         OP_MUL, OP_DIV: begin
            n_c = p0_ff;
            d_c = p1_ff;
         end
         OP_INV: begin
            n_c = NUM_W'(ad_ff);
            d_c = NUM_W'(an_ff);
         end
         default: begin
            n_c = NUM_W'(an_ff);
            d_c = NUM_W'(ad_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.comb) begin
         n_ff <= n_c;
         d_ff <= d_c;
      end else if (cmd.fix && d_ff < 0) begin
         n_ff <= -n_ff;
         d_ff <= -d_ff;
      end
   end

   // binary GCD: strip common twos, then subtract and halve
   logic [MAG_W-1:0] mag_ff, x_ff, y_ff, g_ff, diff_xy, diff_yx, n_mag;
   logic [GK_W-1:0]  k_ff;

   assign n_mag   = n_ff[NUM_W-1] ? MAG_W'(-n_ff) : MAG_W'(n_ff);
   assign diff_xy = x_ff - y_ff;
   assign diff_yx = y_ff - x_ff;

   always_ff @(posedge clock) begin
      if (cmd.ginit) begin
         mag_ff <= n_mag;
         x_ff   <= n_mag;
         y_ff   <= d_ff[MAG_W-1:0];
         k_ff   <= '0;
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + GK_W'(1);
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= diff_xy >> 1;
         end else begin
            y_ff <= diff_yx >> 1;
         end
      end
      if (cmd.gend) begin
         g_ff <= (x_ff | y_ff) << k_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [MAG_W-1:0]  rem_ff, quo_ff, qn_ff;
   logic [MAG_W:0]    rem_t, rem_sub;
   logic [DCNT_W-1:0] cnt_ff;
   logic              ge;

   assign rem_t   = {rem_ff, quo_ff[MAG_W-1]};
   assign rem_sub = rem_t - {1'b0, g_ff};
   assign ge      = (rem_t >= {1'b0, g_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= cmd.div_sel_den ? d_ff[MAG_W-1:0] : mag_ff;
         rem_ff <= '0;
         cnt_ff <= '0;
         if (cmd.div_sel_den) begin
            qn_ff <= quo_ff;
         end
      end else if (cmd.div_step) begin
         rem_ff <= ge ? rem_sub[MAG_W-1:0] : rem_t[MAG_W-1:0];
         quo_ff <= {quo_ff[MAG_W-2:0], ge};
         cnt_ff <= cnt_ff + DCNT_W'(1);
      end
   end

   // status to the controller
   always_comb begin
      sts.err      = (st_ff != ST_OK);
      sts.n_zero   = (n_ff == '0);
      sts.gcd_done = (x_ff == '0) || (y_ff == '0);
      sts.div_done = (cnt_ff == DCNT_W'(MAG_W));
   end

   // output register; errors and zero give 0/1
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status <= st_ff;
         if (st_ff != ST_OK || n_ff == '0) begin
            res_num <= '0;
            res_den <= DEN_W'(1);
         end else begin
            res_num <= n_ff[NUM_W-1] ? -NUM_W'(qn_ff) : NUM_W'(qn_ff);
            res_den <= quo_ff[DEN_W-1:0];
         end
      end
   end

endmodule
`default_nettype wire

FILE: verif/rau_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_tb_if: testbench-side view of the unit's channels
// The request and response interfaces come from the RTL; this file only holds
// the beat types that the testbench moves across them.
// ----------------------------------------------------------------------------
package rau_tb_pkg;
   import rau_pkg::*;

   typedef struct {
      logic [OPCODE_W-1:0]    opcode;
      logic signed [IN_W-1:0] a_num;
      logic signed [IN_W-1:0] a_den;
      logic signed [IN_W-1:0] b_num;
      logic signed [IN_W-1:0] b_den;
   } req_beat_type;

   typedef struct {
      logic signed [NUM_W-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
      logic [STATUS_W-1:0]     status;
   } rsp_beat_type;
endpackage

FILE: verif/rational_arithmetic_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_tb: self-checking bench of the rational unit
// Drives a directed table and then random fraction pairs with random gaps on
// both channels, predicts each reduced fraction and status in the bench, and
// compares every response beat in order against the predicted results.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_tb;
   import rau_pkg::*;
   import rau_tb_pkg::*;

   localparam int N_RANDOM   = 1600;
   localparam int IDLE_LIMIT = 20000;
   localparam int MAXP       = (1 << (OPERAND_BITS - 1)) - 1;

   typedef struct {
      req_beat_type req;
      logic         has_exp;
      rsp_beat_type exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rau_req_if req_chan ();
   rau_rsp_if rsp_chan ();

   rsp_beat_type pending_q[$];
   int        n_errors   = 0;
   int        n_sent     = 0;
   int        n_rcvd     = 0;
   int        n_status[4] = '{0, 0, 0, 0};
   int        idle_cnt   = 0;
   logic      long_hold  = 1'b0;
   logic      stim_done  = 1'b0;

   rational_arithmetic_unit_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // operand as the unit sees it: low OPERAND_BITS, signed, most negative clipped
   function automatic longint clip_operand(logic [IN_W-1:0] raw);
      longint v;
      v = longint'($signed(raw[OPERAND_BITS-1:0]));
      if (v < -longint'(MAXP)) v = -longint'(MAXP);
      return v;
   endfunction

   function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rsp_beat_type predict_fraction(req_beat_type r);
      rsp_beat_type    o;
      longint          an, ad, bn, bd, n, d;
      longint unsigned g;
      logic            uses_b;
      an = clip_operand(r.a_num);
      ad = clip_operand(r.a_den);
      bn = clip_operand(r.b_num);
      bd = clip_operand(r.b_den);
      uses_b = (r.opcode <= OP_DIV);
      o.res_num = 0;
      o.res_den = 1;
      o.status  = ST_OK;
      n = 0;
      d = 1;
      if (ad == 0 || (uses_b && bd == 0)) begin
         o.status = ST_ZDEN;
         return o;
      end
      if (ad < 0) begin
         an = -an;
         ad = -ad;
      end
      if (uses_b && bd < 0) begin
         bn = -bn;
         bd = -bd;
      end
      case (r.opcode)
         OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
         OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         OP_DIV: begin
            if (bn == 0) o.status = ST_DIVZ;
            else begin n = an * bd; d = ad * bn; end
         end
         OP_INV: begin
            if (an == 0) o.status = ST_DIVZ;
            else begin n = ad; d = an; end
         end
         default: begin n = an; d = ad; end
      endcase
      if (o.status != ST_OK) return o;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n == 0) return o;
      g = euclid((n < 0) ? longint'(-n) : n, d);
      o.res_num = n / longint'(g);
      o.res_den = DEN_W'(d / longint'(g));
      return o;
   endfunction

   function automatic logic [IN_W-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return IN_W'($urandom_range(0, 20)) - 10;
         1: return IN_W'($urandom_range(0, 2000)) - 1000;
         2: return $urandom();
         3: return IN_W'($urandom_range(0, 1)) ? IN_W'(MAXP) : -IN_W'(MAXP);
         default: return IN_W'($urandom_range(0, 1 << 16)) * IN_W'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic req_beat_type rand_request();
      req_beat_type r;
      logic [IN_W-1:0] k;
      r.opcode = OPCODE_W'($urandom_range(0, 7));
      r.a_num  = rand_operand();
      r.a_den  = rand_operand();
      r.b_num  = rand_operand();
      r.b_den  = rand_operand();
      // share factors now and then so the reduction has real work to do
      if ($urandom_range(0, 3) == 0) begin
         k = IN_W'($urandom_range(2, 5000));
         r.a_num = IN_W'($urandom_range(0, 40000)) * k;
         r.a_den = IN_W'($urandom_range(1, 40000)) * k;
      end
      return r;
   endfunction

   // hold the sender for a number of cycles
   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // drive one beat and wait for it to be taken
   task automatic send_beat(req_beat_type r);
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= r.opcode;
      req_chan.a_num  <= r.a_num;
      req_chan.a_den  <= r.a_den;
      req_chan.b_num  <= r.b_num;
      req_chan.b_den  <= r.b_den;
      do @(posedge clock); while (!req_chan.ready);
      pending_q.push_back(predict_fraction(r));
      n_sent++;
   endtask

   // lower valid once a burst ends
   task automatic drop_valid();
      req_chan.valid <= 1'b0;
   endtask

   function automatic req_beat_type mk(logic [2:0] op, int an, int ad, int bn, int bd);
      req_beat_type r;
      r.opcode = op;
      r.a_num  = an;
      r.a_den  = ad;
      r.b_num  = bn;
      r.b_den  = bd;
      return r;
   endfunction

   function automatic rsp_beat_type rs(longint n, longint unsigned d, logic [1:0] st);
      rsp_beat_type o;
      o.res_num = n;
      o.res_den = DEN_W'(d);
      o.status  = st;
      return o;
   endfunction

   // sender: directed table, then random beats with gaps and one full drain
   initial begin
      row_type      rows[$];
      rsp_beat_type got;
      int           gap;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_ADD;
      req_chan.a_num  <= '0;
      req_chan.a_den  <= '0;
      req_chan.b_num  <= '0;
      req_chan.b_den  <= '0;
      rows = '{
         '{mk(OP_ADD, 1, 2, 1, 3), 1'b1, rs(5, 6, ST_OK)},
         '{mk(OP_SUB, 1, 2, 1, 2), 1'b1, rs(0, 1, ST_OK)},
         '{mk(OP_MUL, -2, 4, 3, -9), 1'b1, rs(1, 6, ST_OK)},
         '{mk(OP_DIV, 1, 2, 0, 5), 1'b1, rs(0, 1, ST_DIVZ)},
         '{mk(OP_INV, 0, 7, 0, 0), 1'b1, rs(0, 1, ST_DIVZ)},
         '{mk(OP_INV, -3, 6, 9, 0), 1'b1, rs(-2, 1, ST_OK)},
         '{mk(OP_RED, 12, -18, 0, 0), 1'b1, rs(-2, 3, ST_OK)},
         '{mk(3'd6, 10, 4, 1, 1), 1'b1, rs(5, 2, ST_OK)},
         '{mk(3'd7, 0, -4, 1, 1), 1'b1, rs(0, 1, ST_OK)},
         '{mk(OP_ADD, 1, 0, 1, 1), 1'b1, rs(0, 1, ST_ZDEN)},
         '{mk(OP_DIV, 1, 1, 1, 0), 1'b1, rs(0, 1, ST_ZDEN)},
         '{mk(OP_RED, 5, 3, 1, 0), 1'b1, rs(5, 3, ST_OK)},
         '{mk(OP_INV, 0, 0, 1, 1), 1'b1, rs(0, 1, ST_ZDEN)},
         '{mk(OP_MUL, MAXP, 1, MAXP, 1), 1'b0, rs(0, 1, ST_OK)},
         '{mk(OP_ADD, MAXP, MAXP - 1, MAXP, -MAXP), 1'b0, rs(0, 1, ST_OK)},
         '{mk(OP_SUB, 32'h8000_0000, 1, MAXP, 1), 1'b0, rs(0, 1, ST_OK)},
         '{mk(OP_DIV, 32'h8000_0000, 32'h8000_0000, 1, MAXP), 1'b1,
           rs(MAXP, 1, ST_OK)},
         '{mk(OP_MUL, -MAXP, MAXP, MAXP, 3), 1'b0, rs(0, 1, ST_OK)},
         '{mk(OP_DIV, 1, MAXP, MAXP - 2, 1), 1'b0, rs(0, 1, ST_OK)},
         '{mk(OP_INV, 32'h8000_0000, 1, 0, 0), 1'b1, rs(-1, MAXP, ST_OK)},
         '{mk(OP_ADD, -1, -1, -1, -1), 1'b1, rs(2, 1, ST_OK)},
         '{mk(OP_SUB, 32'h5555_5555, 32'hAAAA_AAAB, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
           1'b0, rs(0, 1, ST_OK)}
      };
      @(posedge clock);
      while (reset) @(posedge clock);
      // directed rows; a typed-in expectation must match the predictor too
      foreach (rows[i]) begin
         if (rows[i].has_exp) begin
            got = predict_fraction(rows[i].req);
            if (got.res_num != rows[i].exp.res_num) begin
               $error("row %0d res_num: expected %0d, predictor %0d", i,
                      rows[i].exp.res_num, got.res_num);
               n_errors++;
            end
            if (got.res_den != rows[i].exp.res_den) begin
               $error("row %0d res_den: expected %0d, predictor %0d", i,
                      rows[i].exp.res_den, got.res_den);
               n_errors++;
            end
            if (got.status != rows[i].exp.status) begin
               $error("row %0d status: expected %0d, predictor %0d", i,
                      rows[i].exp.status, got.status);
               n_errors++;
            end
         end
         send_beat(rows[i].req);
         drop_valid();
         idle_cycles(1);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         // one full drain mid-run
         if (i == N_RANDOM / 3) begin
            drop_valid();
            while (pending_q.size() != 0) @(posedge clock);
         end
         // long receiver hold-off while offers keep coming
         if (i == N_RANDOM / 2) long_hold <= 1'b1;
         if (i == N_RANDOM / 2 + 4) long_hold <= 1'b0;
         gap = (i % 200 < 40) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            drop_valid();
            idle_cycles(gap);
         end
         send_beat(rand_request());
      end
      drop_valid();
      stim_done <= 1'b1;
   end

   // receiver: random stalls, plus long hold-offs while long_hold is set, counted here
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // compare each response beat with the oldest predicted result
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_rcvd++;
         if (pending_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            n_errors++;
         end else begin
            want = pending_q.pop_front();
            n_status[want.status]++;
            if (rsp_chan.res_num !== want.res_num) begin
               $error("res_num: expected %0d, got %0d", want.res_num, rsp_chan.res_num);
               n_errors++;
            end
            if (rsp_chan.res_den !== want.res_den) begin
               $error("res_den: expected %0d, got %0d", want.res_den, rsp_chan.res_den);
               n_errors++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               n_errors++;
            end
         end
      end
   end

   // reset, watchdog and end of run
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cnt = 0;
         else
            idle_cnt++;
         if (idle_cnt >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cnt);
            $display("Mismatches found");
            $finish;
         end
         if (stim_done && pending_q.size() == 0) begin
            repeat (300) @(posedge clock);
            $display("covered %0d requests, %0d responses", n_sent, n_rcvd);
            $display("status counts: ok %0d, zero denominator %0d, zero divisor %0d",
                     n_status[0], n_status[1], n_status[2]);
            if (n_errors == 0 && pending_q.size() == 0)
               $display("No mismatches found");
            else
               $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
